// ----- design/i2a_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package i2a_pkg;

    localparam int NumBits    = 32;
    localparam int NumDigits  = 10;
    localparam int BcdW       = 4 * NumDigits;
    localparam int StepCntW   = $clog2(NumBits);
    localparam int DigCntW    = 4;
    localparam int FieldW     = 6;

    localparam logic [7:0] ChZero    = 8'h30;
    localparam logic [7:0] ChMinus   = 8'h2d;
    localparam logic [7:0] ChSpace   = 8'h20;
    localparam logic [7:0] ChHexBase = 8'h57;   // 'a' - 10
    localparam logic [5:0] HexDefaultW = 6'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_PREP,
        ST_SIGN,
        ST_PRE,
        ST_DIG,
        ST_POST
    } fmt_state_t;

    // add 3 to every BCD digit of 5 or more (one double-dabble step)
    function automatic logic [BcdW-1:0] bcd_adjust(input logic [BcdW-1:0] bcd);
        logic [BcdW-1:0] res;
        res = bcd;
        for (int i = 0; i < NumDigits; i++) begin
            if (bcd[4*i +: 4] >= 4'd5) begin
                res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
            end
        end
        return res;
    endfunction

    // number of significant digits, at least one
    function automatic logic [DigCntW-1:0] digit_count(input logic [BcdW-1:0] dig);
        logic [DigCntW-1:0] n;
        n = DigCntW'(1);
        for (int i = 0; i < NumDigits; i++) begin
            if (dig[4*i +: 4] != 4'd0) begin
                n = DigCntW'(i + 1);
            end
        end
        return n;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = ChZero + {4'd0, d};
        end else begin
            c = ChHexBase + {4'd0, d};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- design/i2a_bcd_conv.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Binary to BCD, one double-dabble step per cycle.
module i2a_bcd_conv
    import i2a_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [NumBits-1:0] bin,
    output logic                   done,
    output logic [BcdW-1:0]        bcd
);

    logic [NumBits-1:0]  bin_reg;
    logic [BcdW-1:0]     bcd_reg;
    logic [StepCntW-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [BcdW-1:0]     adj;

    assign adj = bcd_adjust(bcd_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == StepCntW'(NumBits - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            bin_reg <= bin;
            bcd_reg <= '0;
        end else if (busy_reg) begin
            {bcd_reg, bin_reg} <= {adj[BcdW-2:0], bin_reg, 1'b0};
        end
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

`default_nettype wire

// ----- design/integer_to_ascii_formatter.sv -----
`timescale 1ns / 1ps
`default_nettype none

// printf-style %d / %x formatter.
// s_axis: one beat per number. tuser = kind (0 signed decimal, 1 lowercase hex).
//   tdata = number[31:0], field_width[37:32], zero_fill[38], left_align[39].
// m_axis: one beat per character, tdata = ASCII char, tlast on the final one.
// Decimal: the binary-to-BCD unit runs one double-dabble step per cycle, 32 steps.
// Hex: nibbles are used directly.
// Characters leave at one per cycle while the receiver is ready; 1..64 per item.
// s_axis_tready is high only while idle; the final character is parked in the
// output register, so the next number can be taken while it still waits.
// A receiver stall freezes the character sequence; nothing is dropped.
// Reset clears the sequencer and the output valid; no pass over storage.
module integer_to_ascii_formatter
    import i2a_pkg::*;
#(
    parameter int MAX_FIELD_WIDTH = 63
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // number, field_width, zero_fill, left_align
    input  wire logic        s_axis_tuser,   // kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // text_char
    output logic             m_axis_tlast    // last_char
);

    localparam logic [FieldW-1:0] MaxW = FieldW'(MAX_FIELD_WIDTH);

    fmt_state_t state_reg, state_next;

    logic [NumBits-1:0] in_number;
    logic [FieldW-1:0]  in_width;
    logic               in_zfill, in_left, in_kind;
    logic               in_go;
    logic [NumBits-1:0] mag;
    logic [FieldW-1:0]  width_clamp;

    logic [BcdW-1:0]    digits_reg;
    logic [DigCntW-1:0] idx_reg;
    logic [FieldW-1:0]  pad_reg;
    logic [FieldW-1:0]  width_reg;
    logic               neg_reg, left_reg, fill_reg;

    logic               conv_done;
    logic [BcdW-1:0]    conv_bcd;

    logic [DigCntW-1:0] nd;
    logic [FieldW-1:0]  nd_ext;
    logic [FieldW-1:0]  pad_calc;

    logic               out_valid_reg, out_last_reg;
    logic [7:0]         out_char_reg;

    logic               emitting, emit_go, emit_last;
    logic [7:0]         emit_char;

    assign in_number = s_axis_tdata[31:0];
    assign in_width  = s_axis_tdata[37:32];
    assign in_zfill  = s_axis_tdata[38];
    assign in_left   = s_axis_tdata[39];
    assign in_kind   = s_axis_tuser;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_go         = s_axis_tvalid && s_axis_tready;

    assign mag = (in_number[NumBits-1]) ? (~in_number + 1'b1) : in_number;

    always_comb
    begin
        width_clamp = (in_width > MaxW) ? MaxW : in_width;
        if (in_kind && (width_clamp == '0)) begin
            width_clamp = HexDefaultW;
        end
    end

    i2a_bcd_conv u_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_go && !in_kind),
        .bin   (mag),
        .done  (conv_done),
        .bcd   (conv_bcd)
    );

    assign nd       = digit_count(digits_reg);
    assign nd_ext   = FieldW'(nd);
    assign pad_calc = (width_reg > nd_ext) ? (width_reg - nd_ext) : '0;

    // output side of the sequencer
    always_comb
    begin
        emitting  = 1'b0;
        emit_char = ChZero;
        emit_last = 1'b0;
        unique case (state_reg)
            ST_SIGN:
            begin
                emitting  = 1'b1;
                emit_char = ChMinus;
            end
            ST_PRE:
            begin
                emitting  = 1'b1;
                emit_char = fill_reg ? ChZero : ChSpace;
            end
            ST_DIG:
            begin
                emitting  = 1'b1;
                emit_char = digit_char(digits_reg[{idx_reg, 2'b00} +: 4]);
                emit_last = (idx_reg == '0) && !(left_reg && (pad_reg != '0));
            end
            ST_POST:
            begin
                emitting  = 1'b1;
                emit_char = fill_reg ? ChZero : ChSpace;
                emit_last = (pad_reg == FieldW'(1));
            end
            default:
            begin
                emitting = 1'b0;
            end
        endcase
        emit_go = emitting && (!out_valid_reg || m_axis_tready);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_go) begin
                    state_next = in_kind ? ST_PREP : ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (conv_done) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (neg_reg) begin
                    state_next = ST_SIGN;
                end else if (!left_reg && (pad_calc != '0)) begin
                    state_next = ST_PRE;
                end else begin
                    state_next = ST_DIG;
                end
            end
            ST_SIGN:
            begin
                if (emit_go) begin
                    state_next = (!left_reg && (pad_reg != '0)) ? ST_PRE : ST_DIG;
                end
            end
            ST_PRE:
            begin
                if (emit_go && (pad_reg == FieldW'(1))) begin
                    state_next = ST_DIG;
                end
            end
            ST_DIG:
            begin
                if (emit_go && (idx_reg == '0)) begin
                    state_next = (left_reg && (pad_reg != '0)) ? ST_POST : ST_IDLE;
                end
            end
            ST_POST:
            begin
                if (emit_go && (pad_reg == FieldW'(1))) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_go) begin
            width_reg  <= width_clamp;
            neg_reg    <= !in_kind && in_number[NumBits-1];
            left_reg   <= !in_kind && in_left;
            fill_reg   <= in_kind || in_zfill;
            digits_reg <= {{(BcdW-NumBits){1'b0}}, in_number};
        end
        if ((state_reg == ST_CONV) && conv_done) begin
            digits_reg <= conv_bcd;
        end
        if (state_reg == ST_PREP) begin
            idx_reg <= nd - 1'b1;
            pad_reg <= pad_calc;
        end
        if (emit_go) begin
            if (state_reg == ST_DIG) begin
                idx_reg <= idx_reg - 1'b1;
            end
            if ((state_reg == ST_PRE) || (state_reg == ST_POST)) begin
                pad_reg <= pad_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (emit_go) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_go) begin
            out_char_reg <= emit_char;
            out_last_reg <= emit_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tlast  = out_last_reg;

    a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
        conv_done |-> (state_reg == ST_CONV))
        else $error("BCD unit finished outside conversion");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIG) |-> (idx_reg < DigCntW'(NumDigits)))
        else $error("digit index out of range");

    a_hex_skips_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (in_go && in_kind) |=> (state_reg == ST_PREP))
        else $error("hex item did not go straight to prep");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> !emit_go || !$past(emitting) || m_axis_tvalid)
        else $error("output lost during stall");

endmodule

`default_nettype wire
